>>> src/i32asmd_pkg.sv
package i32asmd_pkg;

   localparam int WORD_W = 32;
   // One guard bit for the shifted remainder and one for the borrow
   localparam int ADD_W  = WORD_W + 2;
   localparam int CNT_W  = $clog2(WORD_W);

   typedef enum logic [1:0] {
      OPC_ADD = 2'd0,
      OPC_SUB = 2'd1,
      OPC_MUL = 2'd2,
      OPC_DIV = 2'd3
   } opcode_type;

endpackage

>>> src/int32_add_sub_mul_div_unit.sv
// Add and subtract strobe the result from ST_ALU; multiply from the last step of ST_MUL;
// divide from ST_SIGN after ST_MAG_A, ST_MAG_B and ST_DIV; divide by zero from idle.
// Throughput: one request at a time; busy stays high until the result strobe,
// and a new request may be taken in the cycle the result is strobed.
// The 32-step loops of multiply and divide on the one shared adder set the rate.
// Synchronous active-high reset returns to idle with no strobe; the receiver cannot stall.
module int32_add_sub_mul_div_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   output logic [31:0] rsp_result_value,
   output logic        rsp_divide_by_zero
);

   localparam int W  = i32asmd_pkg::WORD_W;
   localparam int AW = i32asmd_pkg::ADD_W;
   localparam int CW = i32asmd_pkg::CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALU,
      ST_MAG_A,
      ST_MAG_B,
      ST_MUL,
      ST_DIV,
      ST_SIGN
   } state_type;

   state_type            state_ff;
   logic [W-1:0]         x_ff;     // addend, multiplicand, dividend then quotient
   logic [W-1:0]         y_ff;     // second operand, multiplier, divisor
   logic [W-1:0]         acc_ff;   // product accumulator or partial remainder
   logic                 sub_ff;   // subtract for the ST_ALU path
   logic                 neg_ff;   // quotient sign
   logic [CW-1:0]        cnt_ff;
   logic                 rsp_valid_ff;
   logic [W-1:0]         rsp_value_ff;
   logic                 rsp_dz_ff;

   logic [AW-1:0]        add_x;
   logic [AW-1:0]        add_y;
   logic                 add_sub;
   logic [AW-1:0]        add_sum;
   logic [W:0]           rem_shift;
   logic                 div_fits;
   i32asmd_pkg::opcode_type req_op;

   assign req_op    = i32asmd_pkg::opcode_type'(req_opcode);
   // Bring the next dividend bit into the partial remainder
   assign rem_shift = {acc_ff, x_ff[W-1]};
   // No borrow from the trial subtraction: divisor fits
   assign div_fits  = ~add_sum[AW-1];

   // Operand selection for the shared adder
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b0;
      unique case (state_ff)
         ST_ALU: begin
            add_x   = {2'b00, x_ff};
            add_y   = {2'b00, y_ff};
            add_sub = sub_ff;
         end
         ST_MAG_A: begin
            add_y   = {2'b00, x_ff};
            add_sub = 1'b1;
         end
         ST_MAG_B: begin
            add_y   = {2'b00, y_ff};
            add_sub = 1'b1;
         end
         ST_MUL: begin
            add_x   = {2'b00, acc_ff};
            add_y   = y_ff[0] ? {2'b00, x_ff} : '0;
         end
         ST_DIV: begin
            add_x   = {1'b0, rem_shift};
            add_y   = {2'b00, y_ff};
            add_sub = 1'b1;
         end
         ST_SIGN: begin
            add_y   = {2'b00, x_ff};
            add_sub = 1'b1;
         end
         default: begin
            add_sub = 1'b0;
         end
      endcase
   end

   i32asmd_addsub u_addsub (
      .op_x (add_x),
      .op_y (add_y),
      .sub  (add_sub),
      .sum  (add_sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Strobe lasts one cycle only
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  x_ff   <= req_operand_a;
                  y_ff   <= req_operand_b;
                  acc_ff <= '0;
                  cnt_ff <= '0;
                  sub_ff <= (req_op == i32asmd_pkg::OPC_SUB);
                  neg_ff <= req_operand_a[W-1] ^ req_operand_b[W-1];
                  unique case (req_op)
                     i32asmd_pkg::OPC_ADD,
                     i32asmd_pkg::OPC_SUB: state_ff <= ST_ALU;
                     i32asmd_pkg::OPC_MUL: state_ff <= ST_MUL;
                     i32asmd_pkg::OPC_DIV: begin
                        if (req_operand_b == '0) begin
                           // Divide by zero: answer at once with zero and the flag
                           rsp_valid_ff <= 1'b1;
                           rsp_value_ff <= '0;
                           rsp_dz_ff    <= 1'b1;
                        end else begin
                           state_ff <= ST_MAG_A;
                        end
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_ALU: begin
               rsp_valid_ff <= 1'b1;
               rsp_value_ff <= add_sum[W-1:0];
               rsp_dz_ff    <= 1'b0;
               state_ff     <= ST_IDLE;
            end
            ST_MAG_A: begin
               // Take the dividend magnitude; the most negative value gives 2^31
               if (x_ff[W-1]) begin
                  x_ff <= add_sum[W-1:0];
               end
               state_ff <= ST_MAG_B;
            end
            ST_MAG_B: begin
               if (y_ff[W-1]) begin
                  y_ff <= add_sum[W-1:0];
               end
               state_ff <= ST_DIV;
            end
            ST_MUL: begin
               // Add the shifted multiplicand where the multiplier bit is set
               acc_ff <= add_sum[W-1:0];
               x_ff   <= {x_ff[W-2:0], 1'b0};
               y_ff   <= {1'b0, y_ff[W-1:1]};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(W - 1)) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= add_sum[W-1:0];
                  rsp_dz_ff    <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_DIV: begin
               // Restore the remainder when the trial subtraction borrows
               acc_ff <= div_fits ? add_sum[W-1:0] : rem_shift[W-1:0];
               x_ff   <= {x_ff[W-2:0], div_fits};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(W - 1)) begin
                  state_ff <= ST_SIGN;
               end
            end
            ST_SIGN: begin
               rsp_valid_ff <= 1'b1;
               rsp_value_ff <= neg_ff ? add_sum[W-1:0] : x_ff;
               rsp_dz_ff    <= 1'b0;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_value   = rsp_value_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

endmodule

>>> src/i32asmd_addsub.sv
module i32asmd_addsub (
   input  logic [i32asmd_pkg::ADD_W-1:0] op_x,
   input  logic [i32asmd_pkg::ADD_W-1:0] op_y,
   input  logic                          sub,
   output logic [i32asmd_pkg::ADD_W-1:0] sum
);

   logic [i32asmd_pkg::ADD_W-1:0] y_eff;

   // Subtract as x + ~y + 1
   assign y_eff = sub ? ~op_y : op_y;
   assign sum   = op_x + y_eff + {{(i32asmd_pkg::ADD_W-1){1'b0}}, sub};

endmodule
